@@ rtl/lstt_pkg.sv @@
// ----------------------------------------------------------------------------
// lstt_pkg: shared types and constants of the limit switch tray turner
// Position, target and fault codes, register indexes and the result bundle.
// ----------------------------------------------------------------------------
package lstt_pkg;

  localparam int unsigned CfgDataW   = 32;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned TimerCfgW  = 32;
  localparam int unsigned DebCfgW    = 16;
  localparam int unsigned TdataW     = 8;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MOTOR_TIMEOUT = 2'd0,
    REG_TURN_INTERVAL = 2'd1,
    REG_AUTO_TURN     = 2'd2,
    REG_DEBOUNCE      = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    POS_UNKNOWN = 3'd0,
    POS_LEFT    = 3'd1,
    POS_RIGHT   = 3'd2,
    POS_MOVING  = 3'd3,
    POS_ERROR   = 3'd4
  } position_e;

  typedef enum logic [1:0] {
    TGT_UNKNOWN = 2'd0,
    TGT_LEFT    = 2'd1,
    TGT_RIGHT   = 2'd2
  } target_e;

  typedef enum logic [1:0] {
    FAULT_NONE    = 2'd0,
    FAULT_BOTH    = 2'd1,
    FAULT_TIMEOUT = 2'd2
  } fault_e;

  // debounced switch levels after this tick's update
  typedef struct packed {
    logic left;
    logic right;
  } levels_t;

  // controller outputs after this tick's update
  typedef struct packed {
    logic      motor_on;
    position_e position;
    fault_e    fault;
  } ctrl_res_t;

endpackage

@@ rtl/lstt_debounce.sv @@
// ----------------------------------------------------------------------------
// lstt_debounce: quiet-time debouncer for one limit switch
// Accepts the raw level once it has held for the configured number of ticks.
// ----------------------------------------------------------------------------
module lstt_debounce #(
  parameter int unsigned DEBOUNCE_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          advance_i,
  input  logic                          raw_i,
  input  logic [lstt_pkg::DebCfgW-1:0]  debounce_ms_i,
  output logic                          stable_o
);
  import lstt_pkg::*;

  localparam int unsigned CmpW = (DEBOUNCE_WIDTH > DebCfgW) ? DEBOUNCE_WIDTH : DebCfgW;

  logic                      last_q, last_d;
  logic [DEBOUNCE_WIDTH-1:0] count_q, count_d;
  logic                      stable_q, stable_d;

  always_comb begin
    last_d   = last_q;
    count_d  = count_q;
    stable_d = stable_q;
    if (raw_i != last_q) begin
      last_d  = raw_i;
      count_d = '0;
    end else if (count_q != '1) begin
      count_d = count_q + 1'b1;
    end
    if (CmpW'(count_d) >= CmpW'(debounce_ms_i)) begin
      stable_d = raw_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q   <= 1'b0;
      count_q  <= '0;
      stable_q <= 1'b0;
    end else if (advance_i) begin
      last_q   <= last_d;
      count_q  <= count_d;
      stable_q <= stable_d;
    end
  end

  assign stable_o = stable_d;

endmodule

@@ rtl/lstt_ctrl.sv @@
// ----------------------------------------------------------------------------
// lstt_ctrl: tray turn controller
// Arrival, motor timeout, automatic and requested turns, sticky error.
// ----------------------------------------------------------------------------
module lstt_ctrl #(
  parameter int unsigned TIMER_WIDTH = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            advance_i,
  input  lstt_pkg::levels_t               levels_i,
  input  logic                            start_i,
  input  logic                            home_i,
  input  logic [lstt_pkg::TimerCfgW-1:0]  motor_timeout_i,
  input  logic [lstt_pkg::TimerCfgW-1:0]  turn_interval_i,
  input  logic                            auto_turn_i,
  output lstt_pkg::ctrl_res_t             res_o
);
  import lstt_pkg::*;

  logic                   turning_q, turning_d;
  position_e              pos_q, pos_d;
  fault_e                 fault_q, fault_d;
  target_e                tgt_q, tgt_d;
  logic                   lrel_q, lrel_d;
  logic                   rrel_q, rrel_d;
  logic [TIMER_WIDTH-1:0] run_q, run_d;
  logic [TIMER_WIDTH-1:0] slt_q, slt_d;
  logic                   await_q, await_d;

  logic      arrive;
  position_e where;
  logic      want;

  always_comb begin
    turning_d = turning_q;
    pos_d     = pos_q;
    fault_d   = fault_q;
    tgt_d     = tgt_q;
    lrel_d    = lrel_q;
    rrel_d    = rrel_q;
    run_d     = run_q;
    await_d   = await_q;
    slt_d     = (slt_q != '1) ? slt_q + 1'b1 : slt_q;
    arrive    = 1'b0;
    where     = POS_UNKNOWN;
    want      = 1'b0;

    if (levels_i.left && levels_i.right) begin
      turning_d = 1'b0;
      pos_d     = POS_ERROR;
      fault_d   = FAULT_BOTH;
    end else begin
      if (turning_q) begin
        lrel_d = lrel_q | ~levels_i.left;
        rrel_d = rrel_q | ~levels_i.right;
        case (tgt_q)
          TGT_RIGHT: begin
            arrive = lrel_d & levels_i.right;
            where  = POS_RIGHT;
          end
          TGT_LEFT: begin
            arrive = rrel_d & levels_i.left;
            where  = POS_LEFT;
          end
          default: begin
            // homing: left switch wins
            arrive = levels_i.left | levels_i.right;
            where  = levels_i.left ? POS_LEFT : POS_RIGHT;
          end
        endcase
        if (arrive) begin
          turning_d = 1'b0;
          pos_d     = where;
          fault_d   = FAULT_NONE;
          slt_d     = '0;
        end
      end

      if (turning_d) begin
        if (run_q != '1) begin
          run_d = run_q + 1'b1;
        end
        if (TimerCfgW'(run_d) > motor_timeout_i) begin
          turning_d = 1'b0;
          pos_d     = POS_ERROR;
          fault_d   = FAULT_TIMEOUT;
        end
      end

      if (auto_turn_i && !turning_d && pos_d != POS_ERROR) begin
        if (await_q) begin
          // first eligible tick only restarts the interval
          slt_d   = '0;
          await_d = 1'b0;
        end else if (TimerCfgW'(slt_d) >= turn_interval_i) begin
          want = 1'b1;
        end
      end
      if (start_i || (home_i && pos_d == POS_UNKNOWN)) begin
        want = 1'b1;
      end

      if (want && !turning_d && pos_d != POS_ERROR) begin
        case (pos_d)
          POS_LEFT: begin
            tgt_d  = TGT_RIGHT;
            lrel_d = 1'b0;
            rrel_d = 1'b1;
          end
          POS_RIGHT: begin
            tgt_d  = TGT_LEFT;
            lrel_d = 1'b1;
            rrel_d = 1'b0;
          end
          default: begin
            tgt_d  = TGT_UNKNOWN;
            lrel_d = 1'b1;
            rrel_d = 1'b1;
          end
        endcase
        turning_d = 1'b1;
        pos_d     = POS_MOVING;
        run_d     = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      turning_q <= 1'b0;
      pos_q     <= POS_UNKNOWN;
      fault_q   <= FAULT_NONE;
      tgt_q     <= TGT_UNKNOWN;
      lrel_q    <= 1'b1;
      rrel_q    <= 1'b1;
      run_q     <= '0;
      slt_q     <= '0;
      await_q   <= 1'b1;
    end else if (advance_i) begin
      turning_q <= turning_d;
      pos_q     <= pos_d;
      fault_q   <= fault_d;
      tgt_q     <= tgt_d;
      lrel_q    <= lrel_d;
      rrel_q    <= rrel_d;
      run_q     <= run_d;
      slt_q     <= slt_d;
      await_q   <= await_d;
    end
  end

  assign res_o.motor_on = turning_d;
  assign res_o.position = pos_d;
  assign res_o.fault    = fault_d;

endmodule

@@ rtl/limit_switch_tray_turner.sv @@
// ----------------------------------------------------------------------------
// limit_switch_tray_turner: tray turner driven by two limit switches
// One request per millisecond tick in, one status request out.
// ----------------------------------------------------------------------------
// Each accepted input request is one millisecond tick carrying the raw left
// and right switch levels and the start and home requests. The tick updates
// the debouncers and the turn controller in the cycle it is accepted and the
// status lands in the output register on that edge, so a new tick is taken
// every cycle as long as the output register is empty or being drained; the
// single output register is the only thing that sets the rate. Both switches
// stable-pressed forces a sticky error that only reset clears. After reset
// the position is unknown and the registers hold their reset defaults.
// Write configuration only while no tick is in flight.
// ----------------------------------------------------------------------------
module limit_switch_tray_turner #(
  parameter int unsigned DEBOUNCE_WIDTH = 16,
  parameter int unsigned TIMER_WIDTH    = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [lstt_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [lstt_pkg::CfgDataW-1:0] cfg_data_i,
  // tick input
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // tdata: [0] left_raw, [1] right_raw, [2] start_request, [3] home_request,
  //        [7:4] zero
  input  logic [lstt_pkg::TdataW-1:0]   s_axis_tdata,
  // status output
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // tdata: [0] motor_on, [3:1] tray_position, [5:4] fault_code,
  //        [6] left_pressed, [7] right_pressed
  output logic [lstt_pkg::TdataW-1:0]   m_axis_tdata
);
  import lstt_pkg::*;

  // configuration registers
  logic [TimerCfgW-1:0] motor_timeout_q;
  logic [TimerCfgW-1:0] turn_interval_q;
  logic                 auto_turn_q;
  logic [DebCfgW-1:0]   debounce_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      motor_timeout_q <= TimerCfgW'(30000);
      turn_interval_q <= TimerCfgW'(7200000);
      auto_turn_q     <= 1'b0;
      debounce_q      <= DebCfgW'(50);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        REG_MOTOR_TIMEOUT: motor_timeout_q <= cfg_data_i[TimerCfgW-1:0];
        REG_TURN_INTERVAL: turn_interval_q <= cfg_data_i[TimerCfgW-1:0];
        REG_AUTO_TURN:     auto_turn_q     <= cfg_data_i[0];
        REG_DEBOUNCE:      debounce_q      <= cfg_data_i[DebCfgW-1:0];
      endcase
    end
  end

  // take a tick whenever the output register is free or draining
  logic advance;
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign advance       = s_axis_tvalid && s_axis_tready;

  levels_t   levels;
  ctrl_res_t res;

  lstt_debounce #(
    .DEBOUNCE_WIDTH(DEBOUNCE_WIDTH)
  ) u_deb_left (
    .clk_i,
    .rst_ni,
    .advance_i     (advance),
    .raw_i         (s_axis_tdata[0]),
    .debounce_ms_i (debounce_q),
    .stable_o      (levels.left)
  );

  lstt_debounce #(
    .DEBOUNCE_WIDTH(DEBOUNCE_WIDTH)
  ) u_deb_right (
    .clk_i,
    .rst_ni,
    .advance_i     (advance),
    .raw_i         (s_axis_tdata[1]),
    .debounce_ms_i (debounce_q),
    .stable_o      (levels.right)
  );

  lstt_ctrl #(
    .TIMER_WIDTH(TIMER_WIDTH)
  ) u_ctrl (
    .clk_i,
    .rst_ni,
    .advance_i       (advance),
    .levels_i        (levels),
    .start_i         (s_axis_tdata[2]),
    .home_i          (s_axis_tdata[3]),
    .motor_timeout_i (motor_timeout_q),
    .turn_interval_i (turn_interval_q),
    .auto_turn_i     (auto_turn_q),
    .res_o           (res)
  );

  // output register: hold until taken, load on every accepted tick
  logic              out_valid_q, out_valid_d;
  logic [TdataW-1:0] out_data_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= {levels.right, levels.left, res.fault, res.position, res.motor_on};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

@@ rtl/lstt_checker.sv @@
// ----------------------------------------------------------------------------
// lstt_checker: port-level checks of the tray turner
// Flow control and consistency of the reported status over time.
// ----------------------------------------------------------------------------
module lstt_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);

  // stalled output blocks new ticks
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("tick accepted while output stalled");

  // an accepted tick shows a status on the next cycle
  a_tick_gives_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("accepted tick produced no status");

  // stalled status holds
  a_status_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled status changed");

  // motor runs exactly while the tray is reported moving
  a_motor_moving: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[0] == (m_axis_tdata[3:1] == 3'd3)))
    else $error("motor drive disagrees with moving position");

  // a fault is reported exactly in the error position
  a_fault_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((m_axis_tdata[3:1] == 3'd4) == (m_axis_tdata[5:4] != 2'd0)))
    else $error("fault code disagrees with error position");

endmodule

bind limit_switch_tray_turner lstt_checker u_lstt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
